// File: design/bpr_pkg.sv
`default_nettype none
package bpr_pkg;

	localparam int BYTE_W = 8;
	localparam int CNT_W  = 4;
	localparam int PAT_W  = 64;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_MATCH_PATTERN   = 2'd1;
	localparam logic [IDX_W-1:0] REG_REPLACE_PATTERN = 2'd2;

	localparam logic [CNT_W-1:0] LEN_RESET = 4'd6;

	// control broadcast to every window cell
	typedef struct packed {
		logic             app;
		logic [CNT_W-1:0] app_idx;
		logic             shift;
		logic             repl;
		logic [CNT_W-1:0] len;
	} cell_ctl_t;

	typedef struct packed {
		logic              any_match;
		logic              last;
		logic [BYTE_W-1:0] data;
	} out_item_t;

endpackage
`default_nettype wire

// File: design/bpr_cell.sv
`default_nettype none
module bpr_cell #(
	parameter int IDX = 0
) (
	input  wire                          clk,
	input  bpr_pkg::cell_ctl_t           ctl,
	input  wire  [bpr_pkg::BYTE_W-1:0]   in_byte,
	input  wire  [bpr_pkg::BYTE_W-1:0]   nb_byte,
	input  wire  [bpr_pkg::BYTE_W-1:0]   match_byte,
	input  wire  [bpr_pkg::BYTE_W-1:0]   rep_next,
	output logic [bpr_pkg::BYTE_W-1:0]   cur_byte,
	output logic                         eq
);
	import bpr_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);

	logic [BYTE_W-1:0] byte_q;

	// the incoming byte lands here when this cell is the next free slot
	always_comb begin
		cur_byte = (ctl.app && ctl.app_idx == MY_IDX) ? in_byte : byte_q;
		eq       = (cur_byte == match_byte) || (MY_IDX >= ctl.len);
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			if (ctl.repl && NEXT_IDX < ctl.len) begin
				byte_q <= rep_next;
			end else begin
				byte_q <= nb_byte;
			end
		end else begin
			byte_q <= cur_byte;
		end
	end

endmodule
`default_nettype wire

// File: design/bpr_out_buf.sv
`default_nettype none
module bpr_out_buf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wr_en,
	input  bpr_pkg::out_item_t   wr_item,
	output logic                 full,
	output logic                 rd_valid,
	input  wire                  rd_ready,
	output bpr_pkg::out_item_t   rd_item
);
	import bpr_pkg::*;

	localparam logic [1:0] DEPTH = 2'd2;

	out_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign full     = (cnt_q == DEPTH);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign push     = wr_en && !full;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/byte_pattern_replacer_core.sv
// Byte stream search and replace.
// Input bytes arrive on the s_ channel (s_tdata = data byte, s_tlast marks the
// last byte of a buffer). Patched bytes leave on the m_ channel in original
// order; m_tlast marks the final byte of the buffer and m_tuser carries the
// "any match replaced" flag on that byte (0 on all others).
// Pattern length and the match/replace patterns are written on the cfg_
// channel (index 0, 1, 2); the user must write them only while the stream is
// idle, as the block does not enforce it. cfg_ready is always high. A byte that
// completes a window check enters the output buffer in the cycle it is taken.
// Throughput is one byte per cycle while the output buffer has room: the window
// is a row of byte cells that compare in parallel and shift once per cycle.
// A transaction that releases several bytes (end of buffer, or a shortened
// pattern) holds s_tready low as the cell row shifts them out one byte a cycle.
// A two-entry output buffer decouples the sides: input is still taken while a
// result waits, and a stalled receiver only blocks input once it fills.
// Reset empties the window, clears the match flag and sets pattern length 6
// with both patterns zero.
`default_nettype none
module byte_pattern_replacer_core #(
	parameter int MAX_PATTERN = 8
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [bpr_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
	input  wire                          s_tlast,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [bpr_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] out_byte
	output logic                         m_tlast,
	output logic                         m_tuser,   // [0] any_match
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [bpr_pkg::IDX_W-1:0]    cfg_index,
	input  wire  [bpr_pkg::PAT_W-1:0]    cfg_data
);
	import bpr_pkg::*;

	localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_PATTERN);

	logic [CNT_W-1:0] len_q;
	logic [PAT_W-1:0] match_q;
	logic [PAT_W-1:0] rep_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_q;
	logic             last_q;
	logic             seen_q;

	logic [CNT_W-1:0]  len_eff;
	logic              acc;
	logic [CNT_W-1:0]  c;
	logic              p;
	logic              lst;
	logic              full;
	logic              go;
	logic              emit;
	logic              shift;
	logic              repl;
	logic              final_out;
	logic              eq_all;
	logic [BYTE_W-1:0] emit_byte;
	logic              seen_n;
	logic              pend_n;
	logic              last_n;
	cell_ctl_t         ctl;
	out_item_t         wr_item;
	out_item_t         rd_item;

	logic [BYTE_W-1:0]      cur_vec [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq_vec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LEN_RESET;
			match_q <= '0;
			rep_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PATTERN_LENGTH:  len_q   <= cfg_data[CNT_W-1:0];
				REG_MATCH_PATTERN:   match_q <= cfg_data;
				REG_REPLACE_PATTERN: rep_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (len_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (len_q > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = len_q;
		end
	end

	assign s_tready = !pend_q && !last_q && !full;
	assign acc      = s_tvalid && s_tready;
	assign go       = !full;

	// view of the window with the accepted byte already appended
	always_comb begin
		c   = acc ? cnt_q + CNT_W'(1) : cnt_q;
		p   = acc || pend_q;
		lst = acc ? s_tlast : last_q;
	end

	assign eq_all = &eq_vec;

	always_comb begin
		emit      = 1'b0;
		shift     = 1'b0;
		repl      = 1'b0;
		final_out = 1'b0;
		emit_byte = cur_vec[0];
		seen_n    = seen_q;
		pend_n    = pend_q;
		last_n    = last_q;
		if (go) begin
			if (p && c > len_eff) begin
				// surplus from a shortened pattern: drop out unchecked
				emit   = 1'b1;
				shift  = 1'b1;
				pend_n = 1'b1;
				last_n = lst;
			end else if (p && c == len_eff) begin
				emit   = 1'b1;
				shift  = 1'b1;
				repl   = eq_all;
				pend_n = 1'b0;
				seen_n = seen_q || eq_all;
				if (eq_all) begin
					emit_byte = rep_q[BYTE_W-1:0];
				end
				final_out = lst && (c == CNT_W'(1));
				last_n    = lst && !final_out;
			end else if (lst) begin
				emit      = 1'b1;
				shift     = 1'b1;
				pend_n    = 1'b0;
				final_out = (c == CNT_W'(1));
				last_n    = !final_out;
			end else begin
				pend_n = 1'b0;
				last_n = 1'b0;
			end
		end
	end

	always_comb begin
		ctl.app     = acc;
		ctl.app_idx = cnt_q;
		ctl.shift   = shift;
		ctl.repl    = repl;
		ctl.len     = len_eff;
	end

	always_comb begin
		wr_item.data      = emit_byte;
		wr_item.last      = final_out;
		wr_item.any_match = final_out && seen_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
			last_q <= 1'b0;
			seen_q <= 1'b0;
		end else begin
			cnt_q  <= shift ? c - CNT_W'(1) : c;
			pend_q <= pend_n;
			last_q <= last_n;
			seen_q <= final_out ? 1'b0 : seen_n;
		end
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [BYTE_W-1:0] nb;
		logic [BYTE_W-1:0] rn;

		if (i + 1 < MAX_PATTERN) begin : g_nb
			assign nb = cur_vec[i+1];
		end else begin : g_nb_end
			assign nb = '0;
		end

		if (i + 1 < PAT_W / BYTE_W) begin : g_rn
			assign rn = rep_q[BYTE_W*(i+1) +: BYTE_W];
		end else begin : g_rn_end
			assign rn = '0;
		end

		bpr_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.in_byte    (s_tdata),
			.nb_byte    (nb),
			.match_byte (match_q[BYTE_W*i +: BYTE_W]),
			.rep_next   (rn),
			.cur_byte   (cur_vec[i]),
			.eq         (eq_vec[i])
		);
	end

	bpr_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (emit),
		.wr_item  (wr_item),
		.full     (full),
		.rd_valid (m_tvalid),
		.rd_ready (m_tready),
		.rd_item  (rd_item)
	);

	assign m_tdata = rd_item.data;
	assign m_tlast = rd_item.last;
	assign m_tuser = rd_item.any_match;

endmodule
`default_nettype wire

// File: tb/sv/byte_pattern_replacer_core_test.sv
`timescale 1ns / 1ps
module byte_pattern_replacer_core_test;
	import bpr_pkg::*;

	localparam int MAX_PAT = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 16;
	localparam int ITEM_TARGET = 135;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              eob;
	} in_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [BYTE_W-1:0]  s_tdata = '0;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [BYTE_W-1:0]  m_tdata;
	logic               m_tlast;
	logic               m_tuser;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [PAT_W-1:0]   cfg_data = '0;

	byte_pattern_replacer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// configuration mirror
	logic [CNT_W-1:0] pat_len = LEN_RESET;
	logic [PAT_W-1:0] match_pat = '0;
	logic [PAT_W-1:0] repl_pat = '0;

	// predicted window state
	logic [BYTE_W-1:0] win [MAX_PAT];
	int                win_cnt = 0;
	logic              seen_match = 1'b0;

	in_item_t          pending_bytes [$];
	out_item_t         patched_q [$];

	int items_queued = 0;
	int items_sent = 0;
	int items_taken = 0;
	int results_seen = 0;
	int buffers_done = 0;
	int buffers_hit = 0;
	int cfg_writes = 0;
	int errors = 0;
	int cycles = 0;

	bit src_calm = 1'b0;
	bit sink_calm = 1'b0;
	int src_gap = 0;
	int sink_gap = 0;
	int hold_reqs = 0;
	int hold_served = 0;
	int hold_left = 0;

	function automatic int eff_len(input logic [CNT_W-1:0] l);
		if (l == 0)
			return 1;
		if (l > MAX_PAT)
			return MAX_PAT;
		return int'(l);
	endfunction

	function automatic int idle_len();
		return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3))
			: int'($urandom_range(8, 40));
	endfunction

	function automatic void release_oldest();
		out_item_t r;
		r.data = win[0];
		r.last = 1'b0;
		r.any_match = 1'b0;
		patched_q.insert(patched_q.size(), r);
		for (int k = 1; k < win_cnt; k++)
			win[k-1] = win[k];
		win_cnt--;
	endfunction

	// advance the window by one byte and queue every byte it makes final
	function automatic void patch_byte(input logic [BYTE_W-1:0] b, input logic eob);
		int len;
		int before_n;
		logic eq;
		out_item_t tail;
		len = eff_len(pat_len);
		before_n = patched_q.size();
		win[win_cnt] = b;
		win_cnt++;
		while (win_cnt > len)
			release_oldest();
		if (win_cnt == len) begin
			eq = 1'b1;
			for (int k = 0; k < len; k++)
				if (win[k] != match_pat[8*k +: 8])
					eq = 1'b0;
			if (eq) begin
				for (int k = 0; k < len; k++)
					win[k] = repl_pat[8*k +: 8];
				seen_match = 1'b1;
			end
			release_oldest();
		end
		if (eob) begin
			while (win_cnt > 0)
				release_oldest();
			if (patched_q.size() > before_n) begin
				tail = patched_q[patched_q.size() - 1];
				tail.last = 1'b1;
				tail.any_match = seen_match;
				patched_q[patched_q.size() - 1] = tail;
			end
			win_cnt = 0;
			seen_match = 1'b0;
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("[%0t] result %0d: %s got %0h want %0h", $time, results_seen, what, got, want);
	endtask

	// sender
	always @(negedge clk) begin : drive_bytes
		in_item_t nxt;
		if (arst_n && (!s_tvalid || items_taken == items_sent)) begin
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				nxt = pending_bytes.pop_front();
				s_tdata <= nxt.data;
				s_tlast <= nxt.eob;
				s_tvalid <= 1'b1;
				items_sent++;
				src_gap = (src_calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver, with an occasional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_served != hold_reqs) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_gap = (sink_calm || $urandom_range(0, 3) != 0) ? 0 : idle_len();
			end
		end
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin : watch
		out_item_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				patch_byte(s_tdata, s_tlast);
				items_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (patched_q.size() == 0) begin
					report_mismatch("unexpected byte", m_tdata, 0);
				end else begin
					want = patched_q.pop_front();
					if (m_tdata !== want.data)
						report_mismatch("out_byte", m_tdata, want.data);
					if (m_tlast !== want.last)
						report_mismatch("out_last", m_tlast, want.last);
					if (m_tuser !== want.any_match)
						report_mismatch("any_match", m_tuser, want.any_match);
					if (want.last) begin
						buffers_done++;
						if (want.any_match)
							buffers_hit++;
					end
				end
				results_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout: %0d bytes taken, %0d results pending", items_taken,
				patched_q.size());
			$display("byte_pattern_replacer_core_test: done, errors");
			$finish;
		end
	end

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [PAT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PATTERN_LENGTH:  pat_len = val[CNT_W-1:0];
			REG_MATCH_PATTERN:   match_pat = val;
			REG_REPLACE_PATTERN: repl_pat = val;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eob);
		in_item_t it;
		it.data = b;
		it.eob = eob;
		pending_bytes.insert(pending_bytes.size(), it);
		items_queued++;
	endtask

	// hold until every queued byte is taken and every result has arrived
	task automatic wait_idle();
		while (items_taken != items_queued || patched_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// shaped buffers carry copies of the match pattern and its bytes
	task automatic queue_buffer(input int nbytes, input bit shaped, input bit close);
		int len;
		int i;
		logic [BYTE_W-1:0] b;
		len = eff_len(pat_len);
		i = 0;
		while (i < nbytes) begin
			if (shaped && i + len <= nbytes && $urandom_range(0, 2) == 0) begin
				for (int k = 0; k < len; k++)
					push_byte(match_pat[8*k +: 8], close && (i + k == nbytes - 1));
				i += len;
			end else begin
				if (shaped && $urandom_range(0, 1) == 0)
					b = match_pat[8*$urandom_range(0, len - 1) +: 8];
				else
					b = 8'($urandom_range(0, 255));
				push_byte(b, close && (i == nbytes - 1));
				i++;
			end
		end
	endtask

	initial begin : stimulus
		int r;
		int phase_no;
		logic [PAT_W-1:0] pat;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset registers: six zero bytes match and get replaced by zeros
		for (int k = 0; k < 6; k++)
			push_byte(8'h00, k == 5);
		push_byte(8'hFF, 1'b1);
		wait_idle();

		// unused upper pattern bytes must not matter; unused index writes nothing
		cfg_write(REG_PATTERN_LENGTH, 64'd3);
		cfg_write(REG_MATCH_PATTERN, 64'hDEAD_BEEF_00CC_BBAA);
		cfg_write(REG_REPLACE_PATTERN, 64'h1234_5678_9A33_2211);
		cfg_write(REG_UNUSED, '1);
		push_byte(8'hAA, 1'b0);
		push_byte(8'hBB, 1'b0);
		push_byte(8'hCC, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'hBB, 1'b1);
		wait_idle();

		// length 0 acts as 1
		cfg_write(REG_PATTERN_LENGTH, 64'd0);
		cfg_write(REG_MATCH_PATTERN, 64'hFF);
		cfg_write(REG_REPLACE_PATTERN, 64'h00);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hFF, 1'b1);
		wait_idle();

		// length 15 acts as 8; leave the buffer open, then shorten the pattern
		cfg_write(REG_PATTERN_LENGTH, 64'd15);
		cfg_write(REG_MATCH_PATTERN, '1);
		for (int k = 0; k < 7; k++)
			push_byte(8'hFF, 1'b0);
		wait_idle();
		cfg_write(REG_PATTERN_LENGTH, 64'd2);
		cfg_write(REG_MATCH_PATTERN, 64'h0101);
		cfg_write(REG_REPLACE_PATTERN, 64'h0201);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h01, 1'b1);
		wait_idle();

		phase_no = 0;
		while (items_queued < ITEM_TARGET) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				cfg_write(REG_PATTERN_LENGTH, 64'd0);
			else if (r == 1)
				cfg_write(REG_PATTERN_LENGTH, 64'($urandom_range(9, 15)));
			else if (r < 4)
				cfg_write(REG_PATTERN_LENGTH, 64'd8);
			else if (r < 6)
				cfg_write(REG_PATTERN_LENGTH, 64'd1);
			else
				cfg_write(REG_PATTERN_LENGTH, 64'($urandom_range(2, 7)));
			if ($urandom_range(0, 4) != 0) begin
				r = $urandom_range(0, 3);
				if (r == 0)
					pat = {8{8'($urandom_range(0, 255))}};
				else if (r == 1)
					pat = '0;
				else
					pat = {$urandom, $urandom};
				if ($urandom_range(0, 3) == 0)
					pat = pat ^ {$urandom, $urandom} & {8{8'h01}};
				cfg_write(REG_MATCH_PATTERN, pat);
				r = $urandom_range(0, 3);
				if (r == 0)
					cfg_write(REG_REPLACE_PATTERN, match_pat);
				else if (r == 1)
					cfg_write(REG_REPLACE_PATTERN, '1);
				else
					cfg_write(REG_REPLACE_PATTERN, {$urandom, $urandom});
			end
			src_calm = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			if (phase_no == 1) begin
				// long receiver stall while the sender keeps offering bytes
				src_calm = 1'b1;
				hold_reqs++;
				queue_buffer(40, 1'b1, 1'b1);
			end else begin
				r = $urandom_range(1, 3);
				for (int n = 0; n < r; n++)
					queue_buffer(int'($urandom_range(1, 16)), $urandom_range(0, 3) != 0,
						n < r - 1 || $urandom_range(0, 3) != 0);
			end
			wait_idle();
			phase_no++;
		end
		// close any buffer left open by the last phase
		push_byte(8'($urandom_range(0, 255)), 1'b1);
		wait_idle();

		$display("covered %0d input bytes in %0d buffers (%0d with a replacement),",
			items_taken, buffers_done, buffers_hit);
		$display("%0d register writes, %0d patched bytes checked, %0d mismatches",
			cfg_writes, results_seen, errors);
		if (errors == 0)
			$display("byte_pattern_replacer_core_test: done, clean");
		else
			$display("byte_pattern_replacer_core_test: done, errors");
		$finish;
	end

endmodule
